@@ design/etb_pkg.sv @@
// Shared types and constants for the elimination tree builder.
`timescale 1ns / 1ps

package etb_pkg;

    localparam int unsigned NODE_MAX = 1024;
    localparam int unsigned NODE_W   = 10;
    localparam int unsigned CNT_W    = 11;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CHILD = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_ROOT_ERR  = 2'd1;
    localparam logic [1:0] STS_NOT_BUILT = 2'd2;
    localparam logic [1:0] STS_RANGE     = 2'd3;

    // parent value marking a bad load
    localparam logic [CNT_W-1:0] PARENT_BAD = CNT_W'(NODE_MAX);

    typedef struct packed {
        logic [CNT_W-1:0]  parent;
        logic [NODE_W-1:0] son_cnt;
        logic [NODE_W-1:0] first_son;
        logic [CNT_W-1:0]  level;
    } node_word_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_LD_RD_I,
        ST_LD_WR_I,
        ST_LD_RD_P,
        ST_LD_WR_P,
        ST_PF_RD,
        ST_PF_WR,
        ST_FL_RD_I,
        ST_FL_RD_P,
        ST_FL_WR,
        ST_LV_RD_I,
        ST_LV_RD_P,
        ST_LV_WR,
        ST_Q_NODE,
        ST_Q_CHILD
    } etb_state_t;

endpackage

@@ design/elimination_tree_builder.sv @@
// Elimination tree builder: node loads, tree build sequencer and queries.
`timescale 1ns / 1ps

// Nodes arrive in index order (op 0); the transaction marked last, or the one
// at index 1023, closes the tree and starts the build. All per-node state
// (parent, son count, first-son offset, level) lives in one 1024-entry node
// memory with a registered read; the packed child list lives in a second
// memory of 1023 entries. One transaction is handled at a time; the result
// sits in an output register, and a new transaction is taken once that
// register has been emptied. A load reads and rewrites its own node word,
// and when it bumps its parent's son count it then reads and rewrites the
// parent's word as well. The closing load then runs the build: a prefix
// pass over every node, a child list fill over each non-root node and a
// downward level pass over every node, all bound by the single read and
// write port of the node memory. After reset, and at the first load after a
// finished build, a clearing pass zeroes the son counts; no transaction is
// accepted while it runs. A tree with a missing or misplaced parent reports
// the root error (status 1) on the closing load and on every later query
// until a new tree is loaded.
module elimination_tree_builder
    import etb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [NODE_W-1:0]   s_node,
    input  logic                s_has_parent,
    input  logic [NODE_W-1:0]   s_parent_index,
    input  logic                s_last_node,
    input  logic [NODE_W-1:0]   s_slot,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [NODE_W-1:0]   m_son_count,
    output logic [NODE_W-1:0]   m_first_son,
    output logic [CNT_W-1:0]    m_level,
    output logic [NODE_W-1:0]   m_child,
    output logic [CNT_W-1:0]    m_leaf_count,
    output logic [CNT_W-1:0]    m_max_level
);

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    node_word_t        node_mem [0:NODE_MAX-1];
    logic [NODE_W-1:0] child_mem [0:NODE_MAX-2];

    logic              nm_we;
    logic [NODE_W-1:0] nm_waddr;
    node_word_t        nm_wdata;
    logic [NODE_W-1:0] nm_raddr;
    node_word_t        nm_rdata;

    logic              cm_we;
    logic [NODE_W-1:0] cm_waddr;
    logic [NODE_W-1:0] cm_wdata;
    logic [NODE_W-1:0] cm_rdata;

    always_ff @(posedge aclk) begin
        if (nm_we) begin
            node_mem[nm_waddr] <= nm_wdata;
        end
        nm_rdata <= node_mem[nm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cm_we) begin
            child_mem[cm_waddr] <= cm_wdata;
        end
        cm_rdata <= child_mem[s_slot];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    etb_state_t        state_reg,   state_next;
    logic [NODE_W-1:0] i_reg,       i_next;      // sweep / node index
    logic [NODE_W-1:0] cur_reg,     cur_next;    // running prefix sum
    logic [NODE_W-1:0] p_reg,       p_next;      // parent being updated
    node_word_t        hold_reg,    hold_next;   // node word held in level pass
    logic [CNT_W-1:0]  ncnt_reg,    ncnt_next;
    logic              built_reg,   built_next;
    logic              err_reg,     err_next;
    logic [CNT_W-1:0]  leaves_reg,  leaves_next;
    logic [CNT_W-1:0]  deep_reg,    deep_next;
    logic              pend_reg,    pend_next;   // load waiting behind clear
    logic              hp_reg,      hp_next;
    logic [NODE_W-1:0] pi_reg,      pi_next;
    logic              last_reg,    last_next;
    logic              mv_reg,      mv_next;
    logic [1:0]        sts_reg,     sts_next;
    logic [NODE_W-1:0] sc_reg,      sc_next;
    logic [NODE_W-1:0] fs_reg,      fs_next;
    logic [CNT_W-1:0]  lv_reg,      lv_next;
    logic [NODE_W-1:0] ch_reg,      ch_next;
    logic [CNT_W-1:0]  lc_reg,      lc_next;
    logic [CNT_W-1:0]  ml_reg,      ml_next;

    logic              s_fire;
    logic [CNT_W-1:0]  i_ext;
    logic [CNT_W-1:0]  n_m1;
    logic [CNT_W-1:0]  n_m2;
    logic              ld_close;
    logic              ld_bad;
    logic              pf_err;
    logic              last_iter;

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign s_fire  = s_valid && s_ready;
    assign i_ext   = {1'b0, i_reg};
    assign n_m1    = ncnt_reg - CNT_W'(1);
    assign n_m2    = ncnt_reg - CNT_W'(2);

    // load decode: the tree closes on the last flag or when full
    assign ld_close = last_reg || (ncnt_reg == CNT_W'(NODE_MAX - 1));
    assign ld_bad   = !hp_reg || ({1'b0, pi_reg} <= ncnt_reg);
    assign pf_err   = (i_ext != n_m1) && (nm_rdata.parent >= ncnt_reg);
    assign last_iter = (i_ext == n_m1);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR: begin
                if (i_reg == NODE_W'(NODE_MAX - 1)) begin
                    state_next = pend_reg ? ST_LD_RD_I : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_op)
                        OP_LOAD:  state_next = built_reg ? ST_CLR : ST_LD_RD_I;
                        OP_QUERY: begin
                            if (built_reg && !err_reg && ({1'b0, s_node} < ncnt_reg)) begin
                                state_next = ST_Q_NODE;
                            end
                        end
                        OP_CHILD: begin
                            if (built_reg && !err_reg
                                && (({1'b0, s_slot} + CNT_W'(1)) < ncnt_reg)) begin
                                state_next = ST_Q_CHILD;
                            end
                        end
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_RD_I: state_next = ST_LD_WR_I;
            ST_LD_WR_I: begin
                if (!ld_close && !ld_bad) begin
                    state_next = ST_LD_RD_P;
                end else if (ld_close && !(err_reg || hp_reg)) begin
                    state_next = ST_PF_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LD_RD_P: state_next = ST_LD_WR_P;
            ST_LD_WR_P: state_next = ST_IDLE;
            ST_PF_RD:   state_next = ST_PF_WR;
            ST_PF_WR: begin
                if (!last_iter) begin
                    state_next = ST_PF_RD;
                end else if (err_reg || pf_err) begin
                    state_next = ST_IDLE;
                end else if (ncnt_reg == CNT_W'(1)) begin
                    state_next = ST_LV_RD_I;
                end else begin
                    state_next = ST_FL_RD_I;
                end
            end
            ST_FL_RD_I: state_next = ST_FL_RD_P;
            ST_FL_RD_P: state_next = ST_FL_WR;
            ST_FL_WR:   state_next = (i_ext == n_m2) ? ST_LV_RD_I : ST_FL_RD_I;
            ST_LV_RD_I: state_next = ST_LV_RD_P;
            ST_LV_RD_P: state_next = ST_LV_WR;
            ST_LV_WR:   state_next = (i_reg == '0) ? ST_IDLE : ST_LV_RD_I;
            ST_Q_NODE:  state_next = ST_IDLE;
            ST_Q_CHILD: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, memory control and result
    // ------------------------------------------------------------------
    always_comb begin
        logic              emit;
        logic [CNT_W-1:0]  lvl;

        emit        = 1'b0;
        lvl         = '0;
        nm_we       = 1'b0;
        nm_waddr    = i_reg;
        nm_wdata    = nm_rdata;
        nm_raddr    = i_reg;
        cm_we       = 1'b0;
        cm_waddr    = nm_rdata.first_son;
        cm_wdata    = i_reg;

        i_next      = i_reg;
        cur_next    = cur_reg;
        p_next      = p_reg;
        hold_next   = hold_reg;
        ncnt_next   = ncnt_reg;
        built_next  = built_reg;
        err_next    = err_reg;
        leaves_next = leaves_reg;
        deep_next   = deep_reg;
        pend_next   = pend_reg;
        hp_next     = hp_reg;
        pi_next     = pi_reg;
        last_next   = last_reg;

        sts_next    = STS_OK;
        sc_next     = '0;
        fs_next     = '0;
        lv_next     = '0;
        ch_next     = '0;
        lc_next     = '0;
        ml_next     = '0;

        case (state_reg)
            ST_CLR: begin
                nm_we    = 1'b1;
                nm_wdata = '0;
                i_next   = i_reg + NODE_W'(1);
                if (i_reg == NODE_W'(NODE_MAX - 1)) begin
                    pend_next = 1'b0;
                end
            end
            ST_IDLE: begin
                nm_raddr = s_node;
                if (s_fire) begin
                    case (s_op)
                        OP_LOAD: begin
                            hp_next   = s_has_parent;
                            pi_next   = s_parent_index;
                            last_next = s_last_node;
                            if (built_reg) begin
                                // start a new tree
                                pend_next   = 1'b1;
                                i_next      = '0;
                                ncnt_next   = '0;
                                built_next  = 1'b0;
                                err_next    = 1'b0;
                                leaves_next = '0;
                                deep_next   = '0;
                            end
                        end
                        OP_QUERY, OP_CHILD: begin
                            if (!built_reg) begin
                                emit     = 1'b1;
                                sts_next = STS_NOT_BUILT;
                            end else if (err_reg) begin
                                emit     = 1'b1;
                                sts_next = STS_ROOT_ERR;
                            end else if (s_op == OP_QUERY) begin
                                if ({1'b0, s_node} >= ncnt_reg) begin
                                    emit     = 1'b1;
                                    sts_next = STS_RANGE;
                                    lc_next  = leaves_reg;
                                    ml_next  = deep_reg;
                                end
                            end else begin
                                if (({1'b0, s_slot} + CNT_W'(1)) >= ncnt_reg) begin
                                    emit     = 1'b1;
                                    sts_next = STS_RANGE;
                                    lc_next  = leaves_reg;
                                    ml_next  = deep_reg;
                                end
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            ST_LD_RD_I: begin
                nm_raddr = ncnt_reg[NODE_W-1:0];
            end
            ST_LD_WR_I: begin
                // keep son count already gathered for this node
                nm_we    = 1'b1;
                nm_waddr = ncnt_reg[NODE_W-1:0];
                nm_wdata = nm_rdata;
                p_next   = pi_reg;
                if (ld_close) begin
                    nm_wdata.parent = ncnt_reg;
                    err_next        = err_reg || hp_reg;
                    ncnt_next       = ncnt_reg + CNT_W'(1);
                    i_next          = '0;
                    cur_next        = '0;
                    if (err_reg || hp_reg) begin
                        emit       = 1'b1;
                        built_next = 1'b1;
                        sts_next   = STS_ROOT_ERR;
                    end
                end else if (ld_bad) begin
                    nm_wdata.parent = PARENT_BAD;
                    err_next        = 1'b1;
                    ncnt_next       = ncnt_reg + CNT_W'(1);
                    emit            = 1'b1;
                end else begin
                    nm_wdata.parent = {1'b0, pi_reg};
                end
            end
            ST_LD_RD_P: begin
                nm_raddr = p_reg;
            end
            ST_LD_WR_P: begin
                nm_we            = 1'b1;
                nm_waddr         = p_reg;
                nm_wdata         = nm_rdata;
                nm_wdata.son_cnt = nm_rdata.son_cnt + NODE_W'(1);
                ncnt_next        = ncnt_reg + CNT_W'(1);
                emit             = 1'b1;
            end
            ST_PF_RD: begin
                nm_raddr = i_reg;
            end
            ST_PF_WR: begin
                nm_we              = 1'b1;
                nm_wdata.first_son = cur_reg;
                cur_next           = cur_reg + nm_rdata.son_cnt;
                err_next           = err_reg || pf_err;
                i_next             = i_reg + NODE_W'(1);
                if (last_iter) begin
                    if (err_reg || pf_err) begin
                        emit       = 1'b1;
                        built_next = 1'b1;
                        sts_next   = STS_ROOT_ERR;
                    end else if (ncnt_reg == CNT_W'(1)) begin
                        i_next = '0;
                    end else begin
                        i_next = '0;
                    end
                end
            end
            ST_FL_RD_I: begin
                nm_raddr = i_reg;
            end
            ST_FL_RD_P: begin
                p_next   = nm_rdata.parent[NODE_W-1:0];
                nm_raddr = nm_rdata.parent[NODE_W-1:0];
            end
            ST_FL_WR: begin
                // first_son doubles as the fill cursor here
                cm_we              = 1'b1;
                nm_we              = 1'b1;
                nm_waddr           = p_reg;
                nm_wdata.first_son = nm_rdata.first_son + NODE_W'(1);
                i_next             = (i_ext == n_m2) ? n_m1[NODE_W-1:0]
                                                     : i_reg + NODE_W'(1);
            end
            ST_LV_RD_I: begin
                nm_raddr = i_reg;
            end
            ST_LV_RD_P: begin
                hold_next = nm_rdata;
                nm_raddr  = nm_rdata.parent[NODE_W-1:0];
            end
            ST_LV_WR: begin
                lvl = last_iter ? CNT_W'(1) : nm_rdata.level + CNT_W'(1);
                nm_we              = 1'b1;
                nm_wdata           = hold_reg;
                nm_wdata.first_son = hold_reg.first_son - hold_reg.son_cnt;
                nm_wdata.level     = lvl;
                if (hold_reg.son_cnt == '0) begin
                    leaves_next = leaves_reg + CNT_W'(1);
                end
                if (lvl > deep_reg) begin
                    deep_next = lvl;
                end
                i_next = i_reg - NODE_W'(1);
                if (i_reg == '0) begin
                    emit       = 1'b1;
                    built_next = 1'b1;
                    lc_next    = leaves_next;
                    ml_next    = deep_next;
                end
            end
            ST_Q_NODE: begin
                emit    = 1'b1;
                sc_next = nm_rdata.son_cnt;
                fs_next = nm_rdata.first_son;
                lv_next = nm_rdata.level;
                lc_next = leaves_reg;
                ml_next = deep_reg;
            end
            ST_Q_CHILD: begin
                emit    = 1'b1;
                ch_next = cm_rdata;
                lc_next = leaves_reg;
                ml_next = deep_reg;
            end
            default: emit = 1'b0;
        endcase

        if (emit) begin
            mv_next = 1'b1;
        end else begin
            mv_next = mv_reg && !m_ready;
            sts_next = sts_reg;
            sc_next  = sc_reg;
            fs_next  = fs_reg;
            lv_next  = lv_reg;
            ch_next  = ch_reg;
            lc_next  = lc_reg;
            ml_next  = ml_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLR;
            i_reg      <= '0;
            ncnt_reg   <= '0;
            built_reg  <= 1'b0;
            err_reg    <= 1'b0;
            leaves_reg <= '0;
            deep_reg   <= '0;
            pend_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            ncnt_reg   <= ncnt_next;
            built_reg  <= built_next;
            err_reg    <= err_next;
            leaves_reg <= leaves_next;
            deep_reg   <= deep_next;
            pend_reg   <= pend_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        p_reg    <= p_next;
        hold_reg <= hold_next;
        hp_reg   <= hp_next;
        pi_reg   <= pi_next;
        last_reg <= last_next;
        sts_reg  <= sts_next;
        sc_reg   <= sc_next;
        fs_reg   <= fs_next;
        lv_reg   <= lv_next;
        ch_reg   <= ch_next;
        lc_reg   <= lc_next;
        ml_reg   <= ml_next;
    end

    assign m_valid      = mv_reg;
    assign m_status     = sts_reg;
    assign m_son_count  = sc_reg;
    assign m_first_son  = fs_reg;
    assign m_level      = lv_reg;
    assign m_child      = ch_reg;
    assign m_leaf_count = lc_reg;
    assign m_max_level  = ml_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_ready)
        else $error("transaction accepted during clearing pass");

    a_build_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(built_reg) |-> mv_reg)
        else $error("build finished without a result");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ncnt_reg <= CNT_W'(NODE_MAX))
        else $error("node count beyond capacity");

    a_sweep_quiet_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PF_RD || state_reg == ST_FL_RD_I || state_reg == ST_LV_RD_I)
        |-> !mv_reg)
        else $error("result pending while build runs");

endmodule
